FILE: hw/rtl/sdet_pkg.sv
// sdet_pkg: shared types, constants and codes of the scope decimate/edge trigger core.
// No dependencies; used by every module under hw/rtl.

package sdet_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int SUM_W            = 24;
   localparam int SPP_W            = 8;
   localparam int PPF_W            = 7;
   localparam int QUOT_W           = 16;
   localparam int STEP_W           = $clog2(QUOT_W);
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 8;
   localparam int QUEUE_DEPTH      = 4;

   localparam int POINT_DEPTH      = 1024;
   localparam int MAX_FRAME_POINTS = 64;
   localparam int EDGE_SPAN        = 10;

   localparam logic [SPP_W-1:0] SPP_RESET = 8'd4;
   localparam logic [PPF_W-1:0] PPF_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_POINT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_PER_FRAME  = 1'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] point;
      logic                       last_point;
      logic                       edge_found;
   } rsp_type;

   // one queue entry: a finished group to divide and/or the end of a capture
   typedef struct packed {
      logic                    has_point;
      logic                    is_frame;
      logic signed [SUM_W-1:0] sum;
      logic [SPP_W-1:0]        spp;
   } entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_WRITE,
      BK_READ,
      BK_LOAD
   } back_state_type;

endpackage

FILE: hw/rtl/sdet_front.sv
// sdet_front: takes sample items, sums each group and hands queue entries on.
// Depends on sdet_pkg.

module sdet_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sdet_pkg::req_type                  req_data,
   input  logic [sdet_pkg::SPP_W-1:0]         spp_cfg,
   input  logic                               q_full,
   output logic                               q_push,
   output sdet_pkg::entry_type                q_entry
);

   logic signed [sdet_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [sdet_pkg::SPP_W-1:0]        cnt_ff, cnt_in;
   logic [sdet_pkg::SPP_W-1:0]        spp_eff;
   logic                              accept;
   logic                              complete;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign spp_eff   = (spp_cfg == '0) ? sdet_pkg::SPP_W'(1) : spp_cfg;

   always_comb begin
      sum_in   = sum_ff + sdet_pkg::SUM_W'(req_data.sample);
      cnt_in   = cnt_ff + sdet_pkg::SPP_W'(1);
      complete = (cnt_in >= spp_eff);
   end

   assign q_push            = accept && (complete || req_data.last);
   assign q_entry.has_point = complete;
   assign q_entry.is_frame  = req_data.last;
   assign q_entry.sum       = sum_in;
   assign q_entry.spp       = spp_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (accept) begin
         if (complete || req_data.last) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end else begin
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
         end
      end
   end

endmodule

FILE: hw/rtl/sdet_queue.sv
// sdet_queue: short entry queue between the front and back parts.
// Depends on sdet_pkg.

module sdet_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sdet_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output sdet_pkg::entry_type head
);

   localparam int PTR_W  = $clog2(sdet_pkg::QUEUE_DEPTH);
   localparam int FILL_W = $clog2(sdet_pkg::QUEUE_DEPTH + 1);

   sdet_pkg::entry_type  ent_ff [sdet_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]    fill_ff;

   assign full      = (fill_ff == FILL_W'(sdet_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(sdet_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(sdet_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("push into full queue");
`endif

endmodule

FILE: hw/rtl/sdet_back.sv
// sdet_back: divides groups into points, stores them, tracks the rising edge
// and walks the frame out. Depends on sdet_pkg.

module sdet_back #(
   parameter int POINT_DEPTH      = sdet_pkg::POINT_DEPTH,
   parameter int MAX_FRAME_POINTS = sdet_pkg::MAX_FRAME_POINTS,
   parameter int EDGE_SPAN        = sdet_pkg::EDGE_SPAN
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  sdet_pkg::entry_type         q_entry,
   output logic                        q_pop,
   input  logic [sdet_pkg::PPF_W-1:0]  ppf_cfg,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sdet_pkg::rsp_type           rsp_data
);

   localparam int ADDR_W = $clog2(POINT_DEPTH);
   localparam int CNT_W  = $clog2(POINT_DEPTH + 1);
   localparam int IDX_W  = $clog2(POINT_DEPTH + MAX_FRAME_POINTS);
   localparam int K_W    = $clog2(MAX_FRAME_POINTS + 1);
   localparam int QW     = sdet_pkg::QUOT_W;
   localparam int SW     = sdet_pkg::SPP_W;
   localparam int SUMW   = sdet_pkg::SUM_W;
   localparam int STW    = sdet_pkg::STEP_W;

   sdet_pkg::back_state_type state_ff, state_in;

   logic                     frame_ff;
   logic [SW-1:0]            div_ff;
   logic                     neg_ff;
   logic [SW-1:0]            rem_ff, rem_in;
   logic [QW-1:0]            dq_ff, dq_in;
   logic [STW-1:0]           step_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     edge_ff;
   logic [ADDR_W-1:0]        start_ff;
   logic [EDGE_SPAN-1:0]     negline_ff;
   logic [EDGE_SPAN:0]       neg_ext;
   logic [K_W-1:0]           k_ff;
   logic signed [QW-1:0]     rd_data_ff;
   logic                     rsp_valid_ff;
   sdet_pkg::rsp_type        rsp_data_ff;

   logic signed [QW-1:0]     mem [POINT_DEPTH];

   logic                     div_step, wr_point, emit_load, frame_done;
   logic [SUMW-1:0]          mag;
   logic [SW:0]              trial;
   logic                     ge;
   logic signed [QW-1:0]     avg;
   logic                     avg_neg, avg_pos;
   logic                     count_ok;
   logic                     span_ok;
   logic [K_W-1:0]           ppf_eff;
   logic                     k_last;
   logic [IDX_W-1:0]         idx;
   logic                     in_range;
   logic [ADDR_W-1:0]        rd_addr;

   // divider datapath: one quotient bit a cycle on the magnitude
   always_comb begin
      mag   = q_entry.sum[SUMW-1] ? SUMW'(-q_entry.sum) : SUMW'(q_entry.sum);
      trial = {rem_ff, dq_ff[QW-1]};
      ge    = (trial >= {1'b0, div_ff});
      rem_in = ge ? SW'(trial - {1'b0, div_ff}) : trial[SW-1:0];
      dq_in  = {dq_ff[QW-2:0], ge};
      avg    = neg_ff ? QW'(-dq_ff) : dq_ff;
      avg_neg = avg[QW-1];
      avg_pos = !avg[QW-1] && (avg != '0);
   end

   assign count_ok = (32'(count_ff) < 32'(POINT_DEPTH));
   assign span_ok  = (32'(count_ff) >= 32'(EDGE_SPAN));
   assign neg_ext  = {negline_ff, avg_neg};

   always_comb begin
      if (ppf_cfg == '0) begin
         ppf_eff = K_W'(1);
      end else if (32'(ppf_cfg) > 32'(MAX_FRAME_POINTS)) begin
         ppf_eff = K_W'(MAX_FRAME_POINTS);
      end else begin
         ppf_eff = K_W'(ppf_cfg);
      end
   end

   assign k_last   = ((k_ff + K_W'(1)) == ppf_eff);
   assign idx      = IDX_W'(start_ff) + IDX_W'(k_ff);
   assign in_range = (idx < IDX_W'(count_ff));
   assign rd_addr  = idx[ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdet_pkg::BK_IDLE: begin
            if (q_valid) begin
               if (q_entry.has_point) begin
                  state_in = sdet_pkg::BK_DIV;
               end else if (q_entry.is_frame) begin
                  state_in = sdet_pkg::BK_READ;
               end
            end
         end
         sdet_pkg::BK_DIV: begin
            if (step_ff == STW'(QW - 1)) begin
               state_in = sdet_pkg::BK_WRITE;
            end
         end
         sdet_pkg::BK_WRITE: begin
            state_in = frame_ff ? sdet_pkg::BK_READ : sdet_pkg::BK_IDLE;
         end
         sdet_pkg::BK_READ: begin
            state_in = sdet_pkg::BK_LOAD;
         end
         sdet_pkg::BK_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = k_last ? sdet_pkg::BK_IDLE : sdet_pkg::BK_READ;
            end
         end
         default: state_in = sdet_pkg::BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop      = 1'b0;
      div_step   = 1'b0;
      wr_point   = 1'b0;
      emit_load  = 1'b0;
      frame_done = 1'b0;
      unique case (state_ff)
         sdet_pkg::BK_IDLE:  q_pop    = q_valid;
         sdet_pkg::BK_DIV:   div_step = 1'b1;
         sdet_pkg::BK_WRITE: wr_point = 1'b1;
         sdet_pkg::BK_READ:  ;
         sdet_pkg::BK_LOAD: begin
            emit_load  = !rsp_valid_ff || !rsp_stall;
            frame_done = emit_load && k_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_point && count_ok) begin
         mem[count_ff[ADDR_W-1:0]] <= avg;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         frame_ff <= q_entry.is_frame;
         div_ff   <= q_entry.spp;
         neg_ff   <= q_entry.sum[SUMW-1];
         rem_ff   <= mag[SUMW-1:QW];
         dq_ff    <= mag[QW-1:0];
         step_ff  <= '0;
         k_ff     <= '0;
      end else begin
         if (div_step) begin
            rem_ff  <= rem_in;
            dq_ff   <= dq_in;
            step_ff <= step_ff + STW'(1);
         end
         if (emit_load) begin
            k_ff <= k_ff + K_W'(1);
         end
      end
      if (wr_point && count_ok) begin
         negline_ff <= neg_ext[EDGE_SPAN-1:0];
      end
      if (emit_load) begin
         rsp_data_ff.point      <= in_range ? rd_data_ff : '0;
         rsp_data_ff.last_point <= k_last;
         rsp_data_ff.edge_found <= edge_ff;
      end
      if (reset || frame_done) begin
         start_ff <= '0;
      end else if (wr_point && count_ok && !edge_ff && span_ok && negline_ff[EDGE_SPAN-1]
                   && avg_pos) begin
         start_ff <= ADDR_W'(count_ff - CNT_W'(EDGE_SPAN));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdet_pkg::BK_IDLE;
         count_ff     <= '0;
         edge_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (frame_done) begin
            count_ff <= '0;
            edge_ff  <= 1'b0;
         end else if (wr_point && count_ok) begin
            count_ff <= count_ff + CNT_W'(1);
            if (span_ok && negline_ff[EDGE_SPAN-1] && avg_pos) begin
               edge_ff <= 1'b1;
            end
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(POINT_DEPTH))
      else $error("point count past store depth");

   a_edge_in_store: assert property (@(posedge clock) disable iff (reset)
      $rose(edge_ff) |-> 32'(start_ff) + 32'(EDGE_SPAN) < 32'(count_ff))
      else $error("edge start outside stored points");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> count_ff == '0 && !edge_ff)
      else $error("capture state not cleared after frame");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !emit_load)
      else $error("output register overwritten while stalled");
`endif

endmodule

FILE: hw/rtl/scope_decimate_edge_trigger_core.sv
// scope_decimate_edge_trigger_core: top level; settings registers, front, queue, back.
// Depends on sdet_pkg, sdet_front, sdet_queue, sdet_back.
//
//   channel | ports                        | direction
//   req     | req_valid, req_stall, req_data | samples in
//   rsp     | rsp_valid, rsp_stall, rsp_data | frame points out
//   csr     | csr_we, csr_index, csr_wdata  | settings write
//
// A sample is taken whenever req_stall is low. A sample that closes a group queues it;
// the back part then pops it, runs it through the shared divider and stores the point.
// The 4-entry queue buffers groups meanwhile; req_stall rises once it fills.
// After the last sample the frame walk reads each point through BK_READ and BK_LOAD
// from the single point memory read port. Reset is synchronous; the point store is not
// cleared. rsp_stall holds the output register.

module scope_decimate_edge_trigger_core #(
   parameter int POINT_DEPTH      = sdet_pkg::POINT_DEPTH,
   parameter int MAX_FRAME_POINTS = sdet_pkg::MAX_FRAME_POINTS,
   parameter int EDGE_SPAN        = sdet_pkg::EDGE_SPAN
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sdet_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sdet_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [sdet_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sdet_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [sdet_pkg::SPP_W-1:0] spp_ff;
   logic [sdet_pkg::PPF_W-1:0] ppf_ff;

   logic                q_full, q_push, q_pop, q_not_empty;
   sdet_pkg::entry_type q_in, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff <= sdet_pkg::SPP_RESET;
         ppf_ff <= sdet_pkg::PPF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sdet_pkg::CSR_SAMPLES_PER_POINT: spp_ff <= csr_wdata[sdet_pkg::SPP_W-1:0];
            sdet_pkg::CSR_POINTS_PER_FRAME:  ppf_ff <= csr_wdata[sdet_pkg::PPF_W-1:0];
            default: ;
         endcase
      end
   end

   sdet_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .spp_cfg   (spp_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in)
   );

   sdet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   sdet_back #(
      .POINT_DEPTH      (POINT_DEPTH),
      .MAX_FRAME_POINTS (MAX_FRAME_POINTS),
      .EDGE_SPAN        (EDGE_SPAN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .ppf_cfg   (ppf_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
